>>> sv/cosc_pkg.sv
package cosc_pkg;

	// configuration register indexes
	localparam logic [1:0] REG_TRIAL_PERIOD  = 2'd0;
	localparam logic [1:0] REG_LISTEN_WINDOW = 2'd1;
	localparam logic [1:0] REG_LOCK_THRESH   = 2'd2;

	localparam logic [15:0] TRIAL_PERIOD_RST  = 16'd600;
	localparam logic [19:0] LISTEN_WINDOW_RST = 20'd6000;
	localparam logic [3:0]  LOCK_THRESH_RST   = 4'd2;

	// input action codes
	localparam logic ACT_START = 1'b0;
	localparam logic ACT_POLL  = 1'b1;

	// controller operating modes
	localparam logic [1:0] MODE_LISTEN     = 2'd0;
	localparam logic [1:0] MODE_RESTRICTED = 2'd1;
	localparam logic [1:0] MODE_NORMAL     = 2'd2;

	localparam logic [7:0] SAVED_20 = 8'd20;
	localparam logic [7:0] SAVED_40 = 8'd40;
	localparam logic [5:0] SAVE_20  = 6'd20;
	localparam logic [5:0] SAVE_40  = 6'd40;
	localparam logic [5:0] SAVE_NONE = 6'd0;

	typedef struct packed {
		logic [15:0] trial_period_ms;
		logic [19:0] listen_window_ms;
		logic [3:0]  lock_threshold;
	} cfg_t;

	typedef struct packed {
		logic        detecting;
		logic [1:0]  trial_index;
		logic [3:0]  trial_frame_count;
		logic [31:0] trial_start_time;
		logic [31:0] detect_start_time;
		logic        locked_osc_40;
	} det_state_t;

	typedef struct packed {
		logic       reconfigure;
		logic       osc_is_40;
		logic [1:0] op_mode;
		logic       still_detecting;
		logic       save_request;
		logic [5:0] save_mhz;
	} result_t;

endpackage

>>> sv/cosc_decide.sv
module cosc_decide import cosc_pkg::*; (
	input  cfg_t        cfg,
	input  det_state_t  st,
	input  logic        action,
	input  logic [7:0]  saved_mhz,
	input  logic [3:0]  frames_arrived,
	input  logic [31:0] now_ms,
	output det_state_t  st_next,
	output result_t     res
);

	logic [4:0]  sum;
	logic [3:0]  cnt_sat;
	logic [31:0] trial_elapsed;
	logic [31:0] detect_elapsed;
	logic        in_period;
	logic        in_window;
	logic [1:0]  idx_next;

	assign sum            = {1'b0, st.trial_frame_count} + {1'b0, frames_arrived};
	assign cnt_sat        = (sum > {1'b0, cfg.lock_threshold}) ? cfg.lock_threshold : sum[3:0];
	assign trial_elapsed  = now_ms - st.trial_start_time;
	assign detect_elapsed = now_ms - st.detect_start_time;
	assign in_period      = trial_elapsed < {16'd0, cfg.trial_period_ms};
	assign in_window      = detect_elapsed < {12'd0, cfg.listen_window_ms};
	// listen window rotates over the two listen-only trials only
	assign idx_next       = in_window ? {1'b0, ~st.trial_index[0]} : st.trial_index + 2'd1;

	always_comb begin
		st_next = st;
		res.reconfigure     = 1'b0;
		res.osc_is_40       = st.locked_osc_40;
		res.op_mode         = MODE_NORMAL;
		res.save_request    = 1'b0;
		res.save_mhz        = SAVE_NONE;
		if (action == ACT_START) begin
			res.reconfigure = 1'b1;
			if (saved_mhz == SAVED_20 || saved_mhz == SAVED_40) begin
				st_next.locked_osc_40 = (saved_mhz == SAVED_40);
				st_next.detecting     = 1'b0;
				res.osc_is_40         = (saved_mhz == SAVED_40);
			end else begin
				st_next.detecting         = 1'b1;
				st_next.trial_index       = 2'd0;
				st_next.trial_frame_count = 4'd0;
				st_next.trial_start_time  = now_ms;
				st_next.detect_start_time = now_ms;
				res.osc_is_40             = 1'b0;
				res.op_mode               = MODE_LISTEN;
			end
		end else if (st.detecting) begin
			st_next.trial_frame_count = cnt_sat;
			if (cnt_sat >= cfg.lock_threshold) begin
				st_next.locked_osc_40 = st.trial_index[0];
				st_next.detecting     = 1'b0;
				res.reconfigure       = 1'b1;
				res.osc_is_40         = st.trial_index[0];
				res.save_request      = 1'b1;
				res.save_mhz          = st.trial_index[0] ? SAVE_40 : SAVE_20;
			end else if (in_period) begin
				res.osc_is_40 = st.trial_index[0];
				res.op_mode   = st.trial_index[1] ? MODE_RESTRICTED : MODE_LISTEN;
			end else begin
				st_next.trial_start_time  = now_ms;
				st_next.trial_frame_count = 4'd0;
				st_next.trial_index       = idx_next;
				res.reconfigure           = 1'b1;
				res.osc_is_40             = idx_next[0];
				res.op_mode               = idx_next[1] ? MODE_RESTRICTED : MODE_LISTEN;
			end
		end
		res.still_detecting = st_next.detecting;
	end

endmodule

>>> sv/can_oscillator_autodetect.sv
// channel   | handshake            | payload
// ----------+----------------------+---------------------------------------------
// input     | in_valid / in_stall  | action, saved_mhz, frames_arrived, now_ms
// output    | out_valid / out_stall| reconfigure, osc_is_40, op_mode,
//           |                      | still_detecting, save_request, save_mhz
// config    | apb (psel, penable)  | paddr, pwdata, prdata, pready
//
// an item passes from the input register through the decision logic into
// the result register.
// a new item can be taken every cycle unless a stalled result backs up the
// input register; throughput is set by the state update in the decision logic.
// arst_n clears detection state, config registers go to their defaults.
// a stalled result holds in the result register while the input register
// still fills; in_stall rises only when both are occupied.
module can_oscillator_autodetect import cosc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        action,
	input  logic [7:0]  saved_mhz,
	input  logic [3:0]  frames_arrived,
	input  logic [31:0] now_ms,
	// output channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic        reconfigure,
	output logic        osc_is_40,
	output logic [1:0]  op_mode,
	output logic        still_detecting,
	output logic        save_request,
	output logic [5:0]  save_mhz,
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	// configuration registers
	cfg_t cfg_q;

	// detection state, updated as each item leaves the input register
	det_state_t st_q;
	det_state_t st_next;

	// input register
	logic        valid_s1;
	logic        action_s1;
	logic [7:0]  saved_mhz_s1;
	logic [3:0]  frames_s1;
	logic [31:0] now_s1;

	// result register
	logic    out_valid_q;
	result_t res_q;
	result_t res_d;

	logic       advance;
	logic       in_take;
	logic       cfg_wr;
	logic [1:0] reg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign reg_idx = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.trial_period_ms  <= TRIAL_PERIOD_RST;
			cfg_q.listen_window_ms <= LISTEN_WINDOW_RST;
			cfg_q.lock_threshold   <= LOCK_THRESH_RST;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_TRIAL_PERIOD:  cfg_q.trial_period_ms  <= pwdata[15:0];
				REG_LISTEN_WINDOW: cfg_q.listen_window_ms <= pwdata[19:0];
				REG_LOCK_THRESH:   cfg_q.lock_threshold   <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_TRIAL_PERIOD:  prdata = {16'd0, cfg_q.trial_period_ms};
			REG_LISTEN_WINDOW: prdata = {12'd0, cfg_q.listen_window_ms};
			REG_LOCK_THRESH:   prdata = {28'd0, cfg_q.lock_threshold};
			default:           prdata = 32'd0;
		endcase
	end

	// the item in the input register moves on whenever the result slot is free
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			action_s1    <= action;
			saved_mhz_s1 <= saved_mhz;
			frames_s1    <= frames_arrived;
			now_s1       <= now_ms;
		end
	end

	cosc_decide u_decide (
		.cfg            (cfg_q),
		.st             (st_q),
		.action         (action_s1),
		.saved_mhz      (saved_mhz_s1),
		.frames_arrived (frames_s1),
		.now_ms         (now_s1),
		.st_next        (st_next),
		.res            (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (advance) begin
			st_q <= st_next;
		end
	end

	// result slot: refilled on advance, emptied on an unstalled transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_d;
		end
	end

	assign out_valid       = out_valid_q;
	assign reconfigure     = res_q.reconfigure;
	assign osc_is_40       = res_q.osc_is_40;
	assign op_mode         = res_q.op_mode;
	assign still_detecting = res_q.still_detecting;
	assign save_request    = res_q.save_request;
	assign save_mhz        = res_q.save_mhz;

endmodule

>>> tb/osc_decision_checker.sv
`timescale 1ns / 100ps

module osc_decision_checker import cosc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_stall,
	input  logic              action,
	input  logic [7:0]        saved_mhz,
	input  logic [3:0]        frames_arrived,
	input  logic [31:0]       now_ms,
	input  logic              out_valid,
	input  logic              out_stall,
	input  logic              reconfigure,
	input  logic              osc_is_40,
	input  logic [1:0]        op_mode,
	input  logic              still_detecting,
	input  logic              save_request,
	input  logic [5:0]        save_mhz,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [3:0]        paddr,
	input  logic [31:0]       pwdata,
	input  logic [31:0]       prdata,
	input  logic              pready,
	output int unsigned       errors,
	output int unsigned       decisions_owed
);

	det_state_t st;
	cfg_t       cfg;
	result_t    decision_q[$];

	function automatic result_t trial_setting(input logic reconf);
		result_t r;
		r = '0;
		r.reconfigure = reconf;
		r.osc_is_40 = st.trial_index[0];
		r.op_mode = st.trial_index[1] ? MODE_RESTRICTED : MODE_LISTEN;
		r.save_mhz = SAVE_NONE;
		return r;
	endfunction

	function automatic result_t locked_setting(input logic reconf, input logic save);
		result_t r;
		r = '0;
		r.reconfigure = reconf;
		r.osc_is_40 = st.locked_osc_40;
		r.op_mode = MODE_NORMAL;
		r.save_request = save;
		r.save_mhz = !save ? SAVE_NONE : (st.locked_osc_40 ? SAVE_40 : SAVE_20);
		return r;
	endfunction

	// advances the detection state by one transfer and returns its decision
	function automatic result_t predict_decision(input logic act, input logic [7:0] stored,
			input logic [3:0] frames, input logic [31:0] stamp);
		result_t     r;
		logic [4:0]  sum;
		logic [31:0] elapsed;
		if (act == ACT_START) begin
			if (stored == SAVED_20 || stored == SAVED_40) begin
				st.locked_osc_40 = (stored == SAVED_40);
				st.detecting = 1'b0;
				r = locked_setting(1'b1, 1'b0);
			end else begin
				st.detecting = 1'b1;
				st.trial_index = 2'd0;
				st.trial_frame_count = 4'd0;
				st.trial_start_time = stamp;
				st.detect_start_time = stamp;
				r = trial_setting(1'b1);
			end
		end else if (!st.detecting) begin
			r = locked_setting(1'b0, 1'b0);
		end else begin
			sum = {1'b0, st.trial_frame_count} + {1'b0, frames};
			st.trial_frame_count = (sum > {1'b0, cfg.lock_threshold}) ?
				cfg.lock_threshold : sum[3:0];
			elapsed = stamp - st.trial_start_time;
			if (st.trial_frame_count >= cfg.lock_threshold) begin
				st.locked_osc_40 = st.trial_index[0];
				st.detecting = 1'b0;
				r = locked_setting(1'b1, 1'b1);
			end else if (elapsed < {16'd0, cfg.trial_period_ms}) begin
				r = trial_setting(1'b0);
			end else begin
				st.trial_start_time = stamp;
				st.trial_frame_count = 4'd0;
				elapsed = stamp - st.detect_start_time;
				// inside the listen window only the two listen-only trials rotate
				if (elapsed < {12'd0, cfg.listen_window_ms})
					st.trial_index = {1'b0, ~st.trial_index[0]};
				else
					st.trial_index = st.trial_index + 2'd1;
				r = trial_setting(1'b1);
			end
		end
		r.still_detecting = st.detecting;
		return r;
	endfunction

	task automatic check_field(input string what, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s expected %0d got %0d", $time, what, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		result_t     want;
		logic [31:0] reg_value;
		if (!arst_n) begin
			st = '0;
			cfg = '{TRIAL_PERIOD_RST, LISTEN_WINDOW_RST, LOCK_THRESH_RST};
			decision_q.delete();
			errors = 0;
			decisions_owed = 0;
		end else begin
			// result side first: nothing leaves in the cycle it arrives
			if (out_valid && !out_stall) begin
				if (decision_q.size() == 0) begin
					errors++;
					$display("%0t: result transfer expected none got reconfigure %0d osc_is_40 %0d",
						$time, reconfigure, osc_is_40);
				end else begin
					want = decision_q.pop_front();
					check_field("reconfigure", 32'(want.reconfigure), 32'(reconfigure));
					check_field("osc_is_40", 32'(want.osc_is_40), 32'(osc_is_40));
					check_field("op_mode", 32'(want.op_mode), 32'(op_mode));
					check_field("still_detecting", 32'(want.still_detecting),
						32'(still_detecting));
					check_field("save_request", 32'(want.save_request), 32'(save_request));
					check_field("save_mhz", 32'(want.save_mhz), 32'(save_mhz));
				end
			end
			if (psel && penable && pready) begin
				case (paddr[3:2])
					REG_TRIAL_PERIOD:  reg_value = {16'd0, cfg.trial_period_ms};
					REG_LISTEN_WINDOW: reg_value = {12'd0, cfg.listen_window_ms};
					REG_LOCK_THRESH:   reg_value = {28'd0, cfg.lock_threshold};
					default:           reg_value = prdata;
				endcase
				if (pwrite) begin
					case (paddr[3:2])
						REG_TRIAL_PERIOD:  cfg.trial_period_ms = pwdata[15:0];
						REG_LISTEN_WINDOW: cfg.listen_window_ms = pwdata[19:0];
						REG_LOCK_THRESH:   cfg.lock_threshold = pwdata[3:0];
						default: ;
					endcase
				end else begin
					check_field("register readback", reg_value, prdata);
				end
			end
			if (in_valid && !in_stall)
				decision_q.push_back(predict_decision(action, saved_mhz, frames_arrived, now_ms));
			decisions_owed = decision_q.size();
		end
	end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
	import cosc_pkg::*;

	// generous bound: every transfer waiting out a full gap and a full stall, many times over
	localparam int unsigned RUN_LIMIT = 400000;
	localparam int unsigned PHASES = 8;
	localparam int unsigned PHASE_ITEMS = 125;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic        action;
	logic [7:0]  saved_mhz;
	logic [3:0]  frames_arrived;
	logic [31:0] now_ms;
	logic        out_valid;
	logic        out_stall;
	logic        reconfigure;
	logic        osc_is_40;
	logic [1:0]  op_mode;
	logic        still_detecting;
	logic        save_request;
	logic [5:0]  save_mhz;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	int unsigned errors;
	int unsigned decisions_owed;
	int unsigned cycles = 0;

	// calm phases run both sides without any idle cycles
	logic        calm;
	int unsigned cur_period;
	logic [31:0] wall_ms;

	can_oscillator_autodetect dut (.*);

	osc_decision_checker checker_i (.*);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// run watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == RUN_LIMIT) begin
			$display("testbench: done, errors");
			$finish;
		end
	end

	// result side: random stall before each transfer
	initial begin : sink
		int unsigned hold;
		out_stall <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			hold = calm ? 0 : $urandom_range(0, 14);
			if (hold != 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!(out_valid && !out_stall));
		end
	end

	// one input transfer after a random gap; valid stays up if the next gap is zero
	task automatic send_item(input logic act, input logic [7:0] stored,
			input logic [3:0] frames, input logic [31:0] stamp);
		int unsigned hold;
		hold = calm ? 0 : $urandom_range(0, 14);
		if (hold != 0) begin
			in_valid <= 1'b0;
			repeat (hold) @(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		saved_mhz <= stored;
		frames_arrived <= frames;
		now_ms <= stamp;
		do @(posedge clk); while (in_stall);
	endtask

	// setup, access, then idle with psel low so psel never bounces in a step
	task automatic apb_access(input logic wr, input logic [1:0] idx, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// hold off the sender until every decision has come back
	task automatic drain;
		in_valid <= 1'b0;
		do @(posedge clk); while (decisions_owed != 0);
	endtask

	// registers change only with the block idle; each write is read back
	task automatic configure(input logic [15:0] period, input logic [19:0] window,
			input logic [3:0] thresh);
		drain();
		apb_access(1'b1, REG_TRIAL_PERIOD, {16'd0, period});
		apb_access(1'b1, REG_LISTEN_WINDOW, {12'd0, window});
		apb_access(1'b1, REG_LOCK_THRESH, {28'd0, thresh});
		apb_access(1'b0, REG_TRIAL_PERIOD, 32'd0);
		apb_access(1'b0, REG_LISTEN_WINDOW, 32'd0);
		apb_access(1'b0, REG_LOCK_THRESH, 32'd0);
		cur_period = {16'd0, period};
	endtask

	// detection sessions: a start, then a run of polls with time moving forward
	task automatic run_sessions(input int unsigned count);
		int unsigned sent;
		int unsigned polls;
		logic [7:0]  stored;
		logic [3:0]  frames;
		sent = 0;
		while (sent < count) begin
			case ($urandom_range(0, 9))
				0:       stored = SAVED_20;
				1:       stored = SAVED_40;
				default: stored = 8'($urandom_range(0, 255));
			endcase
			send_item(ACT_START, stored, 4'($urandom), wall_ms);
			sent++;
			polls = $urandom_range(1, 30);
			repeat (polls) begin
				// mostly short steps so trials rotate, now and then a jump anywhere
				if ($urandom_range(0, 15) == 0)
					wall_ms = $urandom();
				else
					wall_ms = wall_ms + $urandom_range(0, 2 * cur_period + 4);
				case ($urandom_range(0, 9))
					0, 1:    frames = 4'd1;
					2:       frames = 4'($urandom);
					default: frames = 4'd0;
				endcase
				send_item(ACT_POLL, 8'($urandom), frames, wall_ms);
				sent++;
			end
		end
	endtask

	initial begin : stimulus
		int unsigned phase;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		action <= ACT_START;
		saved_mhz <= 8'd0;
		frames_arrived <= 4'd0;
		now_ms <= 32'd0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= 4'd0;
		pwdata <= 32'd0;
		calm = 1'b0;
		cur_period = {16'd0, TRIAL_PERIOD_RST};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset defaults: poll before any start reports the 20 MHz lock
		send_item(ACT_POLL, 8'd0, 4'd15, 32'd0);
		// saved values lock at once without a save
		send_item(ACT_START, SAVED_40, 4'd0, 32'd5);
		send_item(ACT_POLL, 8'd255, 4'd15, 32'hFFFF_FFFF);
		send_item(ACT_START, SAVED_20, 4'd0, 32'd7);
		// unknown value: trial 0, then rotation at the period boundary
		send_item(ACT_START, 8'd0, 4'd0, 32'd1000);
		send_item(ACT_POLL, 8'd0, 4'd0, 32'd1100);
		send_item(ACT_POLL, 8'd0, 4'd0, 32'd1600);
		send_item(ACT_POLL, 8'd0, 4'd1, 32'd1700);
		// frame count saturates and locks trial 1 with a save
		send_item(ACT_POLL, 8'd0, 4'd15, 32'd1710);
		// time wraps past zero during a trial
		send_item(ACT_START, 8'd255, 4'd0, 32'hFFFF_FF00);
		send_item(ACT_POLL, 8'd0, 4'd0, 32'h0000_0200);
		// start while detecting: restart, then abandon on a valid value
		send_item(ACT_START, 8'd41, 4'd0, 32'h0000_0100);
		send_item(ACT_START, SAVED_40, 4'd0, 32'h0000_0110);
		// past the listen window the restricted trials join the rotation
		send_item(ACT_START, 8'd19, 4'd0, 32'd10000);
		send_item(ACT_POLL, 8'd0, 4'd0, 32'd10600);
		send_item(ACT_POLL, 8'd0, 4'd0, 32'd16100);
		send_item(ACT_POLL, 8'd0, 4'd0, 32'd16800);
		send_item(ACT_POLL, 8'd0, 4'd0, 32'd17400);
		send_item(ACT_POLL, 8'd0, 4'd2, 32'd17500);
		// zero threshold locks on the first poll
		configure(16'd600, 20'd6000, 4'd0);
		send_item(ACT_START, 8'd0, 4'd0, 32'd0);
		send_item(ACT_POLL, 8'd0, 4'd0, 32'd1);
		// zero period rotates on every poll
		configure(16'd0, 20'hF_FFFF, 4'd15);
		send_item(ACT_START, 8'd21, 4'd0, 32'd50);
		send_item(ACT_POLL, 8'd0, 4'd3, 32'd50);
		// threshold lowered under a running count locks on the next poll
		configure(16'hFFFF, 20'd0, 4'd15);
		send_item(ACT_START, 8'd255, 4'd0, 32'd100);
		send_item(ACT_POLL, 8'd0, 4'd9, 32'd200);
		configure(16'hFFFF, 20'd0, 4'd4);
		send_item(ACT_POLL, 8'd0, 4'd0, 32'd300);

		// random sessions over several register settings, extremes first
		for (phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: configure(16'd1, 20'd0, 4'd1);
				1: configure(16'hFFFF, 20'hF_FFFF, 4'd15);
				2: configure(16'd0, 20'd0, 4'd0);
				3: configure(TRIAL_PERIOD_RST, LISTEN_WINDOW_RST, LOCK_THRESH_RST);
				default: configure(16'($urandom_range(0, 40)), 20'($urandom_range(0, 200)),
					4'($urandom_range(1, 8)));
			endcase
			calm = (phase == 3 || phase == 6);
			wall_ms = $urandom();
			run_sessions(PHASE_ITEMS);
		end
		calm = 1'b0;

		drain();
		repeat (8) @(posedge clk);
		@(negedge clk);
		if (errors == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule
